// ===== hdl/float32_to_half_convert_assert.svh =====
// Assertion macros shared by the converter RTL.
`ifndef FLOAT32_TO_HALF_CONVERT_ASSERT_SVH
`define FLOAT32_TO_HALF_CONVERT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define F2H_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define F2H_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/f2h_pkg.sv =====
`default_nettype none

package f2h_pkg;

  localparam int SingleW = 32;
  localparam int HalfW   = 16;

  // Biased single exponent limits for each class of result.
  localparam logic [7:0] ExpNormMax = 8'd142;  // unbiased +15
  localparam logic [7:0] ExpSubMax  = 8'd112;  // unbiased -15
  localparam logic [7:0] ExpSubMin  = 8'd103;  // unbiased -24

  // Single bias minus half bias.
  localparam logic [7:0] HalfExpOffset = 8'd112;
  // Subnormal right shift is SubShiftBase minus the biased exponent.
  localparam logic [7:0] SubShiftBase  = 8'd126;

  localparam logic [HalfW-2:0] HalfInf = 15'h7c00;

  typedef logic [SingleW-1:0] single_t;
  typedef logic [HalfW-1:0]   half_t;

endpackage

`default_nettype wire

// ===== hdl/float32_to_half_convert.sv =====
// Single-precision to half-precision converter.
// Input channel: in_valid / in_ready carry one binary32 word on single_bits.
// Output channel: out_valid / out_ready carry one binary16 word on half_bits.
// Rounding is to nearest with ties away from zero; NaN and overflow give
// signed infinity, magnitudes below the smallest half subnormal give zero.
// A word passes an input register, then the conversion logic, then the
// result register.
// Throughput is one word per cycle while out_ready is high; the two registers
// form a two-stage pipeline, so both stages can hold words at once.
// When the receiver holds out_ready low, the result register keeps its word
// and the input register fills; in_ready drops only once both are full, and
// rises again in the cycle the receiver takes a word.
// Reset clears both valid flags and holds in_ready low while it is asserted.
// No state is kept between words, so no flush is ever needed.
`default_nettype none

module float32_to_half_convert (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire f2h_pkg::single_t  single_bits,
  output logic                   out_valid,
  input  wire                    out_ready,
  output f2h_pkg::half_t         half_bits
);

  `include "float32_to_half_convert_assert.svh"

  logic             held_valid;
  f2h_pkg::single_t held_single;
  f2h_pkg::half_t   conv_half;
  logic             advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !rst && (!held_valid || advance);

  f2h_core u_core (
    .single_bits (held_single),
    .half_bits   (conv_half)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_single <= single_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid) begin
      half_bits <= conv_half;
    end
  end

  `F2H_ASSERT_NEXT(a_accept_loads, clk, rst, in_valid && in_ready,
    held_valid && (held_single == $past(single_bits)), "accepted word not held")
  `F2H_ASSERT_NEXT(a_stage_moves, clk, rst, held_valid && advance,
    out_valid && (half_bits == $past(conv_half)), "converted word not registered")
  `F2H_ASSERT_IMPLY(a_sign_kept, clk, rst, held_valid,
    conv_half[15] == held_single[31], "sign not carried through")
  `F2H_ASSERT_IMPLY(a_no_nan, clk, rst, out_valid && (half_bits[14:10] == 5'h1f),
    half_bits[9:0] == 10'd0, "result exponent all ones with nonzero fraction")

endmodule

`default_nettype wire

// ===== hdl/f2h_core.sv =====
`default_nettype none

module f2h_core (
  input  wire f2h_pkg::single_t single_bits,
  output f2h_pkg::half_t        half_bits
);

  logic        sgn;
  logic [7:0]  exp_field;
  logic [22:0] frac;
  logic [7:0]  sh_full;
  logic [4:0]  sh;
  logic [24:0] sig_ext;
  logic [24:0] sub_wide;
  logic [14:0] sub_mag;
  logic [7:0]  exp_off;
  logic [14:0] norm_mag;
  logic [14:0] mag;

  assign sgn       = single_bits[31];
  assign exp_field = single_bits[30:23];
  assign frac      = single_bits[22:0];

  // Subnormal path: the significand with its hidden one, one guard bit below,
  // shifted so that bit 0 is the round bit and bits 10..1 the fraction.
  assign sh_full  = 8'(f2h_pkg::SubShiftBase - exp_field);
  assign sh       = sh_full[4:0];
  assign sig_ext  = {1'b1, frac, 1'b0};
  assign sub_wide = sig_ext >> sh;
  assign sub_mag  = {5'd0, sub_wide[10:1]} + 15'(sub_wide[0]);

  // Normal path: a fraction carry ripples into the exponent, and an exponent
  // that reaches 31 leaves a zero fraction, which is exactly infinity.
  assign exp_off  = 8'(exp_field - f2h_pkg::HalfExpOffset);
  assign norm_mag = {exp_off[4:0], frac[22:13]} + 15'(frac[12]);

  always_comb begin
    if (exp_field > f2h_pkg::ExpNormMax) begin
      mag = f2h_pkg::HalfInf;
    end else if (exp_field < f2h_pkg::ExpSubMin) begin
      mag = 15'd0;
    end else if (exp_field <= f2h_pkg::ExpSubMax) begin
      mag = sub_mag;
    end else begin
      mag = norm_mag;
    end
  end

  assign half_bits = {sgn, mag};

endmodule

`default_nettype wire
